// File: rtl/sdo_pkg.sv
package sdo_pkg;

    // Datapath widths of the shared unit and its accumulators.
    localparam int CW = 36;   // CORDIC x and y
    localparam int ZW = 34;   // CORDIC residual angle
    localparam int AW = 40;   // multiplier first operand and accumulators
    localparam int BW = 32;   // multiplier second operand
    localparam int PW = AW + BW;
    localparam int LW = 58;   // lever sum

    localparam logic signed [BW-1:0] GAIN_Q30   = 32'sd652032874;
    localparam logic signed [BW-1:0] INV_PI_Q32 = 32'sd1367130551;

    // Register indexes.
    localparam logic [2:0] REG_WHEEL_RADIUS   = 3'd0;
    localparam logic [2:0] REG_HALF_TREAD     = 3'd1;
    localparam logic [2:0] REG_HALF_WHEELBASE = 3'd2;
    localparam logic [2:0] REG_INV_LEVER_NORM = 3'd3;
    localparam logic [2:0] REG_TIME_STEP      = 3'd4;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_WMUL = 17'h00002,
        S_WROT = 17'h00004,
        S_WGX  = 17'h00008,
        S_WGY  = 17'h00010,
        S_VEL  = 17'h00020,
        S_LEVT = 17'h00040,
        S_LEVW = 17'h00080,
        S_YAW  = 17'h00100,
        S_HROT = 17'h00200,
        S_HGX  = 17'h00400,
        S_HGY  = 17'h00800,
        S_POSX = 17'h01000,
        S_POSY = 17'h02000,
        S_DTH1 = 17'h04000,
        S_DTH2 = 17'h08000,
        S_OUT  = 17'h10000
    } state_t;

    // Arctangent of 2^-i as a 32 bit binary angle.
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Arithmetic right shift that rounds half up.
    function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] v,
                                                       input logic [5:0] n);
        logic signed [PW-1:0] bias;
        bias = PW'(1) <<< (n - 6'd1);
        return (v + bias) >>> n;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [PW-1:0] v);
        logic signed [23:0] r;
        if (v > PW'(24'sh7FFFFF)) begin
            r = 24'sh7FFFFF;
        end else if (v < -PW'(64'sd8388608)) begin
            r = -24'sd8388608;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (v > PW'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -PW'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/sdo_cordic.sv
module sdo_cordic
    import sdo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic [31:0]          ang_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic                 done
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;
    logic [IW-1:0]        it_reg, it_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic [31:0]          a_fold;
    logic                 flip;
    logic signed [ZW-1:0] atan_z;

    // Fold the angle into the right half plane by negating the vector.
    assign flip   = (ang_in + 32'h4000_0000) >= 32'h8000_0000;
    assign a_fold = flip ? ang_in + 32'h8000_0000 : ang_in;
    assign atan_z = ZW'(atan_lut(5'(it_reg)));

    // One micro-rotation per cycle.
    always_comb begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        cz_next   = cz_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            cx_next   = flip ? -x_in : x_in;
            cy_next   = flip ? -y_in : y_in;
            cz_next   = {{(ZW-32){a_fold[31]}}, a_fold};
            it_next   = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!cz_reg[ZW-1]) begin
                cx_next = cx_reg - (cy_reg >>> it_reg);
                cy_next = cy_reg + (cx_reg >>> it_reg);
                cz_next = cz_reg - atan_z;
            end else begin
                cx_next = cx_reg + (cy_reg >>> it_reg);
                cy_next = cy_reg - (cx_reg >>> it_reg);
                cz_next = cz_reg + atan_z;
            end
            it_next = it_reg + 1'b1;
            if (it_reg == IW'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        it_reg <= it_next;
    end

    assign x_out = cx_reg;
    assign y_out = cy_reg;
    assign done  = done_reg;

endmodule

// File: rtl/swerve_drive_odometry.sv
// Swerve drive odometry. Each input beat carries the spin rate and steering angle
// of the four wheels; each produces one output beat with the updated pose and the
// body velocities. A single CORDIC rotator, stepping once per cycle, and a single
// 40x32 multiplier are shared by the five rotations and all products.
// s_tready is low from acceptance until the result beat has been taken.
// The user must write the registers through the APB port only while the block
// is idle; the block itself does not enforce this.
module swerve_drive_odometry
    import sdo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // fr_wheel_rate, fl_wheel_rate, rl_wheel_rate, rr_wheel_rate,
    // fr_steer_angle, fl_steer_angle, rl_steer_angle, rr_steer_angle (16 bit each)
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pose_x[31:0], pose_y[63:32], pose_heading[87:64], body_vx[111:88],
    // body_vy[135:112], body_yaw_rate[159:136]
    output logic [159:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    state_t state_reg, state_next;

    logic [15:0] radius_reg, tread_reg, base_reg;
    logic [23:0] inv_reg, ts_reg;
    logic [127:0] in_reg;
    logic [1:0]  k_reg, k_next;

    logic signed [AW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [AW-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic signed [LW-1:0] lev_reg, lev_next;
    logic signed [23:0]   vx_reg, vx_next, vy_reg, vy_next, yaw_reg, yaw_next;
    logic signed [AW-1:0] wx_reg, wx_next, wy_reg, wy_next, t_reg, t_next;
    logic signed [31:0]   posx_reg, posx_next, posy_reg, posy_next;
    logic [23:0]          head_reg, head_next;
    logic                 mv_reg, mv_next;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod, prod_r30;

    logic                 c_start, c_done;
    logic signed [CW-1:0] c_xin, c_yin, c_x, c_y;
    logic [31:0]          c_ang;
    logic [15:0]          rate_k, ang_k;
    logic                 wr_en;

    assign rate_k = in_reg[16*k_reg +: 16];
    assign ang_k  = in_reg[64 + 16*k_reg +: 16];

    sdo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (c_start),
        .x_in   (c_xin),
        .y_in   (c_yin),
        .ang_in (c_ang),
        .x_out  (c_x),
        .y_out  (c_y),
        .done   (c_done)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_WMUL: begin
                mul_a = AW'($signed(rate_k));
                mul_b = BW'($signed({1'b0, radius_reg}));
            end
            S_WGX, S_HGX: begin
                mul_a = AW'(c_x);
                mul_b = GAIN_Q30;
            end
            S_WGY, S_HGY: begin
                mul_a = AW'(c_y);
                mul_b = GAIN_Q30;
            end
            S_LEVT: begin
                mul_a = lx_reg;
                mul_b = BW'($signed({1'b0, tread_reg}));
            end
            S_LEVW: begin
                mul_a = ly_reg;
                mul_b = BW'($signed({1'b0, base_reg}));
            end
            S_YAW: begin
                mul_a = AW'(rnd_shift(PW'(lev_reg), 6'd16));
                mul_b = BW'($signed({1'b0, inv_reg}));
            end
            S_POSX: begin
                mul_a = wx_reg;
                mul_b = BW'($signed({1'b0, ts_reg}));
            end
            S_POSY: begin
                mul_a = wy_reg;
                mul_b = BW'($signed({1'b0, ts_reg}));
            end
            S_DTH1: begin
                mul_a = AW'(yaw_reg);
                mul_b = BW'($signed({1'b0, ts_reg}));
            end
            S_DTH2: begin
                mul_a = t_reg;
                mul_b = INV_PI_Q32;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_r30 = rnd_shift(prod, 6'd30);

    // CORDIC loading: wheel vector from the rate product, body vector for the heading.
    always_comb begin
        if (state_reg == S_WMUL) begin
            c_start = 1'b1;
            c_xin   = CW'(prod);
            c_yin   = '0;
            c_ang   = {ang_k, 16'h0000};
        end else begin
            c_start = (state_reg == S_YAW);
            c_xin   = CW'(vx_reg);
            c_yin   = CW'(vy_reg);
            c_ang   = {head_reg, 8'h00};
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        lx_next    = lx_reg;
        ly_next    = ly_reg;
        lev_next   = lev_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        yaw_next   = yaw_reg;
        wx_next    = wx_reg;
        wy_next    = wy_reg;
        t_next     = t_reg;
        posx_next  = posx_reg;
        posy_next  = posy_reg;
        head_next  = head_reg;
        mv_next    = mv_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    k_next     = '0;
                    sx_next    = '0;
                    sy_next    = '0;
                    lx_next    = '0;
                    ly_next    = '0;
                    state_next = S_WMUL;
                end
            end
            S_WMUL: state_next = S_WROT;
            S_WROT: begin
                if (c_done) begin
                    state_next = S_WGX;
                end
            end
            S_WGX: begin
                sx_next = sx_reg + AW'(prod_r30);
                lx_next = (k_reg == 2'd1 || k_reg == 2'd2) ? lx_reg - AW'(prod_r30)
                                                           : lx_reg + AW'(prod_r30);
                state_next = S_WGY;
            end
            S_WGY: begin
                sy_next = sy_reg + AW'(prod_r30);
                ly_next = k_reg[1] ? ly_reg - AW'(prod_r30) : ly_reg + AW'(prod_r30);
                k_next  = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? S_VEL : S_WMUL;
            end
            S_VEL: begin
                vx_next = sat24(rnd_shift(PW'(sx_reg), 6'd10));
                vy_next = sat24(rnd_shift(PW'(sy_reg), 6'd10));
                state_next = S_LEVT;
            end
            S_LEVT: begin
                lev_next   = LW'(prod);
                state_next = S_LEVW;
            end
            S_LEVW: begin
                lev_next   = lev_reg + LW'(prod);
                state_next = S_YAW;
            end
            S_YAW: begin
                yaw_next   = sat24(rnd_shift(prod, 6'd24));
                state_next = S_HROT;
            end
            S_HROT: begin
                if (c_done) begin
                    state_next = S_HGX;
                end
            end
            S_HGX: begin
                wx_next    = AW'(prod_r30);
                state_next = S_HGY;
            end
            S_HGY: begin
                wy_next    = AW'(prod_r30);
                state_next = S_POSX;
            end
            S_POSX: begin
                posx_next  = sat32(PW'(posx_reg) + rnd_shift(prod, 6'd24));
                state_next = S_POSY;
            end
            S_POSY: begin
                posy_next  = sat32(PW'(posy_reg) + rnd_shift(prod, 6'd24));
                state_next = S_DTH1;
            end
            S_DTH1: begin
                t_next     = AW'(rnd_shift(prod, 6'd16));
                state_next = S_DTH2;
            end
            S_DTH2: begin
                head_next  = head_reg + 24'(rnd_shift(prod, 6'd33));
                mv_next    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    mv_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Configuration writes.
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mv_reg     <= 1'b0;
            posx_reg   <= '0;
            posy_reg   <= '0;
            head_reg   <= '0;
            radius_reg <= 16'd4915;
            tread_reg  <= 16'd16384;
            base_reg   <= 16'd16384;
            inv_reg    <= 24'd131072;
            ts_reg     <= 24'd167772;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            posx_reg  <= posx_next;
            posy_reg  <= posy_next;
            head_reg  <= head_next;
            if (wr_en) begin
                unique case (paddr[4:2])
                    REG_WHEEL_RADIUS:   radius_reg <= pwdata[15:0];
                    REG_HALF_TREAD:     tread_reg  <= pwdata[15:0];
                    REG_HALF_WHEELBASE: base_reg   <= pwdata[15:0];
                    REG_INV_LEVER_NORM: inv_reg    <= pwdata[23:0];
                    REG_TIME_STEP:      ts_reg     <= pwdata[23:0];
                    default: ;
                endcase
            end
        end
        if (state_reg == S_IDLE && s_tvalid) begin
            in_reg <= s_tdata;
        end
        k_reg   <= k_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        lx_reg  <= lx_next;
        ly_reg  <= ly_next;
        lev_reg <= lev_next;
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        yaw_reg <= yaw_next;
        wx_reg  <= wx_next;
        wy_reg  <= wy_next;
        t_reg   <= t_next;
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            REG_WHEEL_RADIUS:   prdata = {16'h0000, radius_reg};
            REG_HALF_TREAD:     prdata = {16'h0000, tread_reg};
            REG_HALF_WHEELBASE: prdata = {16'h0000, base_reg};
            REG_INV_LEVER_NORM: prdata = {8'h00, inv_reg};
            REG_TIME_STEP:      prdata = {8'h00, ts_reg};
            default:            prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {yaw_reg, vy_reg, vx_reg, head_reg, posy_reg, posx_reg};

endmodule

// File: rtl/sdo_checker.sv
module sdo_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);

    // Nothing is offered straight after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat offered after reset");

    // One beat in flight: never ready for input while a result waits.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // A result is never offered straight after a beat is accepted.
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared in the cycle after acceptance");

    // Once the result is taken, the block returns to idle.
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("block not idle after result beat");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind swerve_drive_odometry sdo_checker u_sdo_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
